/* hdl/ipv4_five_tuple_acl_filter_core_defines.svh */
// Assertion macros for the five-tuple ACL filter checker.
// Depends on nothing; expects clk and rst_n in the scope where used.
`ifndef IPV4_FIVE_TUPLE_ACL_FILTER_CORE_DEFINES_SVH
`define IPV4_FIVE_TUPLE_ACL_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define ACLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define ACLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/aclf_pkg.sv */
// Shared types and constants for the five-tuple ACL filter.
// Used by the controller, datapath and top level.
package aclf_pkg;

  localparam int unsigned RULES_DEF = 64;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned SLOT_SPAN = 1 << SLOT_W;
  localparam int unsigned ENTRY_W   = 104;

  localparam logic [15:0] WILDCARD_PORT  = 16'h0000;
  localparam logic [6:0]  COUNT_MAX      = 7'd127;
  localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
  localparam logic [7:0]  MIN_IP_FRAME   = 8'd34;
  localparam logic [7:0]  TCP_NEED       = 8'd20;
  localparam logic [7:0]  UDP_NEED       = 8'd8;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_RULE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT
  } aclf_state_t;

  typedef struct packed {
    logic byte_en;
    logic last_en;
    logic rule_wr;
    logic scan_rd;
    logic emit;
  } aclf_cmd_t;

  typedef struct packed {
    logic checked;
    logic scan_last;
    logic out_free;
  } aclf_sts_t;

endpackage

/* hdl/ipv4_five_tuple_acl_filter_core.sv */
// Top level of the IPv4 five-tuple exact-match ACL filter.
// Depends on aclf_pkg, aclf_ctrl and aclf_dpath.
//
//   channel  direction  words carried
//   in_      input      frame bytes (kind 0) or rule writes (kind 1)
//   out_     output     one drop/matched/checked result per frame
//
// A frame byte that is not last, and a rule write, leave the controller idle.
// A last byte of a frame that fails the IPv4 TCP/UDP checks goes straight to
// the result hand-off; a checked frame first scans min(RULES,64) slots of the
// single-read-port rule memory, one slot per cycle, then passes a tail state.
// Reset is synchronous, active low; it clears all rule valid bits at once.
// A result waiting on out_ready stalls the next frame only at its result hand-off.
module ipv4_five_tuple_acl_filter_core import aclf_pkg::*; #(
  parameter int unsigned RULES = RULES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_pkt_last,
  input  logic [5:0]  in_rule_slot,
  input  logic [31:0] in_rule_src_addr,
  input  logic [31:0] in_rule_dst_addr,
  input  logic [7:0]  in_rule_protocol,
  input  logic [15:0] in_rule_src_port,
  input  logic [15:0] in_rule_dst_port,
  input  logic        in_rule_deny,
  input  logic        in_rule_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drop,
  output logic        out_matched,
  output logic        out_checked
);

  aclf_cmd_t cmd;
  aclf_sts_t sts;

  aclf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_kind     (in_kind),
    .in_pkt_last (in_pkt_last),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  aclf_dpath #(
    .RULES (RULES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_pkt_byte      (in_pkt_byte),
    .in_rule_slot     (in_rule_slot),
    .in_rule_src_addr (in_rule_src_addr),
    .in_rule_dst_addr (in_rule_dst_addr),
    .in_rule_protocol (in_rule_protocol),
    .in_rule_src_port (in_rule_src_port),
    .in_rule_dst_port (in_rule_dst_port),
    .in_rule_deny     (in_rule_deny),
    .in_rule_valid    (in_rule_valid),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drop         (out_drop),
    .out_matched      (out_matched),
    .out_checked      (out_checked)
  );

endmodule

/* hdl/aclf_ctrl.sv */
// Controller for the ACL filter: accepts words, sequences the table scan
// and the result hand-off. Depends on aclf_pkg.
module aclf_ctrl import aclf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  input  logic      in_pkt_last,
  output logic      in_ready,
  input  aclf_sts_t sts,
  output aclf_cmd_t cmd
);

  aclf_state_t state_r, state_nxt;
  logic        accept;

  // Input is open only while idle
  assign accept = in_valid && (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_kind == KIND_BYTE) && in_pkt_last) begin
          state_nxt = sts.checked ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.emit    = 1'b0;
    case (state_r)
      ST_IDLE: in_ready    = 1'b1;
      ST_SCAN: cmd.scan_rd = 1'b1;
      ST_TAIL: cmd.scan_rd = 1'b0;
      ST_EMIT: cmd.emit    = sts.out_free;
      default: in_ready    = 1'b0;
    endcase
    cmd.byte_en = accept && (in_kind == KIND_BYTE);
    cmd.last_en = accept && (in_kind == KIND_BYTE) && in_pkt_last;
    cmd.rule_wr = accept && (in_kind == KIND_RULE);
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/aclf_dpath.sv */
// Datapath for the ACL filter: header capture, frame checks, rule table
// memory with scan compare, and the result register. Depends on aclf_pkg.
module aclf_dpath import aclf_pkg::*; #(
  parameter int unsigned RULES = RULES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  aclf_cmd_t   cmd,
  output aclf_sts_t   sts,
  input  logic [7:0]  in_pkt_byte,
  input  logic [5:0]  in_rule_slot,
  input  logic [31:0] in_rule_src_addr,
  input  logic [31:0] in_rule_dst_addr,
  input  logic [7:0]  in_rule_protocol,
  input  logic [15:0] in_rule_src_port,
  input  logic [15:0] in_rule_dst_port,
  input  logic        in_rule_deny,
  input  logic        in_rule_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drop,
  output logic        out_matched,
  output logic        out_checked
);

  // Slots above the slot field's span can never be written
  localparam int unsigned DEPTH = (RULES < SLOT_SPAN) ? RULES : SLOT_SPAN;
  localparam int unsigned IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Frame capture registers
  logic [6:0]  byte_count_r, byte_count_nxt;
  logic [15:0] ether_type_r, ether_type_nxt;
  logic [3:0]  hlen_r, hlen_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_addr_r, src_addr_nxt;
  logic [31:0] dst_addr_r, dst_addr_nxt;
  logic [15:0] src_port_r, src_port_nxt;
  logic [15:0] dst_port_r, dst_port_nxt;

  logic [3:0]  ihl_cur;
  logic [7:0]  port_off;
  logic [7:0]  idx;

  // Frame check
  logic [7:0]  frame_len;
  logic [7:0]  need_len;
  logic        is_tcp, is_udp;
  logic        frame_ok;
  logic        checked_r;

  // Rule table
  logic [ENTRY_W-1:0] rule_mem [DEPTH];
  logic [DEPTH-1:0]   rule_vld_r;
  logic [DEPTH-1:0]   rule_deny_r;
  logic               wr_en;
  logic [IDXW-1:0]    wr_idx;

  // Scan
  logic [IDXW-1:0]    scan_idx_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic [IDXW-1:0]    rd_idx_r;
  logic               rd_vld_r;
  logic               entry_ok;
  logic               wc_eq, rp_eq;
  logic               wc_hit_r, wc_deny_r, rp_hit_r, rp_deny_r;

  // Result register
  logic               out_valid_r;
  logic               out_drop_r, out_matched_r, out_checked_r;

  // Capture header fields from the byte stream
  always_comb begin
    ihl_cur  = (byte_count_r == 7'd14) ? in_pkt_byte[7:4] : hlen_r;
    port_off = ETH_HDR_BYTES + {2'b00, ihl_cur, 2'b00};
    idx      = {1'b0, byte_count_r};

    byte_count_nxt = byte_count_r;
    ether_type_nxt = ether_type_r;
    hlen_nxt       = hlen_r;
    proto_nxt      = proto_r;
    src_addr_nxt   = src_addr_r;
    dst_addr_nxt   = dst_addr_r;
    src_port_nxt   = src_port_r;
    dst_port_nxt   = dst_port_r;

    if (cmd.emit) begin
      byte_count_nxt = '0;
      ether_type_nxt = '0;
      hlen_nxt       = '0;
      proto_nxt      = '0;
      src_addr_nxt   = '0;
      dst_addr_nxt   = '0;
      src_port_nxt   = '0;
      dst_port_nxt   = '0;
    end else if (cmd.byte_en) begin
      if (idx == 8'd12) ether_type_nxt[15:8] = in_pkt_byte;
      if (idx == 8'd13) ether_type_nxt[7:0]  = in_pkt_byte;
      if (idx == 8'd14) hlen_nxt             = in_pkt_byte[7:4];
      if (idx == 8'd23) proto_nxt            = in_pkt_byte;
      if ((idx >= 8'd26) && (idx <= 8'd29)) src_addr_nxt = {src_addr_r[23:0], in_pkt_byte};
      if ((idx >= 8'd30) && (idx <= 8'd33)) dst_addr_nxt = {dst_addr_r[23:0], in_pkt_byte};
      // Ports may overlap header bytes when the IHL is small
      if (idx == port_off)         src_port_nxt[15:8] = in_pkt_byte;
      if (idx == port_off + 8'd1)  src_port_nxt[7:0]  = in_pkt_byte;
      if (idx == port_off + 8'd2)  dst_port_nxt[15:8] = in_pkt_byte;
      if (idx == port_off + 8'd3)  dst_port_nxt[7:0]  = in_pkt_byte;
      if (byte_count_r != COUNT_MAX) byte_count_nxt = byte_count_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      ether_type_r <= '0;
      hlen_r       <= '0;
      proto_r      <= '0;
      src_addr_r   <= '0;
      dst_addr_r   <= '0;
      src_port_r   <= '0;
      dst_port_r   <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      ether_type_r <= ether_type_nxt;
      hlen_r       <= hlen_nxt;
      proto_r      <= proto_nxt;
      src_addr_r   <= src_addr_nxt;
      dst_addr_r   <= dst_addr_nxt;
      src_port_r   <= src_port_nxt;
      dst_port_r   <= dst_port_nxt;
    end
  end

  // Qualify the frame on its last byte; header fields are already held
  always_comb begin
    frame_len = {1'b0, byte_count_r} + 8'd1;
    is_tcp    = (proto_r == PROTO_TCP);
    is_udp    = (proto_r == PROTO_UDP);
    need_len  = ETH_HDR_BYTES + {2'b00, hlen_r, 2'b00} + (is_tcp ? TCP_NEED : UDP_NEED);
    frame_ok  = (ether_type_r == ETHERTYPE_IPV4) && (frame_len >= MIN_IP_FRAME) &&
                (is_tcp || is_udp) && (frame_len >= need_len);
  end

  assign sts.checked = frame_ok;

  always_ff @(posedge clk) begin
    if (cmd.last_en) begin
      checked_r <= frame_ok;
    end
  end

  // Rule writes; slots past the table are dropped
  assign wr_en  = cmd.rule_wr && (32'(in_rule_slot) < RULES);
  assign wr_idx = in_rule_slot[IDXW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_mem[wr_idx] <= {in_rule_src_addr, in_rule_dst_addr, in_rule_protocol,
                           in_rule_src_port, in_rule_dst_port};
    end
    if (cmd.scan_rd) begin
      rd_data_r <= rule_mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_vld_r <= '0;
    end else if (wr_en) begin
      rule_vld_r[wr_idx] <= in_rule_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_deny_r[wr_idx] <= in_rule_deny;
    end
  end

  // Advance the scan address, one slot per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.last_en) begin
        scan_idx_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_idx_r <= scan_idx_r;
    end
  end

  assign sts.scan_last = (scan_idx_r == IDXW'(DEPTH - 1));

  // Compare the read entry against the wildcard key and the exact key
  assign entry_ok = rd_vld_r && rule_vld_r[rd_idx_r];
  assign wc_eq    = (rd_data_r == {src_addr_r, dst_addr_r, proto_r, WILDCARD_PORT,
                                   dst_port_r});
  assign rp_eq    = (rd_data_r == {src_addr_r, dst_addr_r, proto_r, src_port_r,
                                   dst_port_r});

  // Keep the first (lowest slot) hit of each lookup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_hit_r <= 1'b0;
      rp_hit_r <= 1'b0;
    end else if (cmd.last_en) begin
      wc_hit_r <= 1'b0;
      rp_hit_r <= 1'b0;
    end else begin
      if (entry_ok && wc_eq && !wc_hit_r) wc_hit_r <= 1'b1;
      if (entry_ok && rp_eq && !rp_hit_r) rp_hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_ok && wc_eq && !wc_hit_r) wc_deny_r <= rule_deny_r[rd_idx_r];
    if (entry_ok && rp_eq && !rp_hit_r) rp_deny_r <= rule_deny_r[rd_idx_r];
  end

  // Result register; wildcard lookup takes precedence
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_checked_r <= checked_r;
      out_matched_r <= checked_r && (wc_hit_r || rp_hit_r);
      out_drop_r    <= checked_r && (wc_hit_r ? wc_deny_r : (rp_hit_r && rp_deny_r));
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drop    = out_drop_r;
  assign out_matched = out_matched_r;
  assign out_checked = out_checked_r;

endmodule

/* hdl/aclf_checker.sv */
// Port-level checker for the ACL filter, bound to the top level.
// Depends on aclf_pkg and ipv4_five_tuple_acl_filter_core_defines.svh.
`include "ipv4_five_tuple_acl_filter_core_defines.svh"

module aclf_checker import aclf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_kind,
  input logic       in_pkt_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_drop,
  input logic       out_matched,
  input logic       out_checked
);

  // Hold a stalled result word
  `ACLF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drop) && $stable(out_matched) && $stable(out_checked), "result changed while stalled")

  // Drop only on a match
  `ACLF_ASSERT_NOW(a_drop_matched, out_valid && out_drop, out_matched, "drop without a matching rule")

  // Match only on a checked frame
  `ACLF_ASSERT_NOW(a_match_checked, out_valid && out_matched, out_checked, "match on an unchecked frame")

  // A last frame byte closes the input until its result is built
  `ACLF_ASSERT_NEXT(a_last_blocks, in_valid && in_ready && (in_kind == KIND_BYTE) && in_pkt_last, !in_ready, "input open right after a last byte")

endmodule

bind ipv4_five_tuple_acl_filter_core aclf_checker u_aclf_checker (.*);

/* dv/tb_ipv4_five_tuple_acl_filter_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the IPv4 five-tuple ACL filter core.
// Depends on aclf_pkg and ipv4_five_tuple_acl_filter_core; a scoreboard class
// predicts each frame verdict from the bytes and rule writes it sees accepted.
module tb_ipv4_five_tuple_acl_filter_core;
  import aclf_pkg::*;

  localparam int RULE_SLOTS    = RULES_DEF;
  localparam int FLAG_VALID    = 1;
  localparam int FLAG_DENY     = 0;
  localparam int TOTAL_WORDS   = 1950;
  localparam int LONG_HOLD     = 600;
  localparam int TAIL_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 2000000;

  // One word on the input channel
  typedef struct packed {
    logic        kind;
    logic [7:0]  pkt_byte;
    logic        pkt_last;
    logic [5:0]  rule_slot;
    logic [31:0] rule_src_addr;
    logic [31:0] rule_dst_addr;
    logic [7:0]  rule_protocol;
    logic [15:0] rule_src_port;
    logic [15:0] rule_dst_port;
    logic        rule_deny;
    logic        rule_valid;
  } acl_word_t;

  // One verdict word on the result channel
  typedef struct packed {
    logic drop;
    logic matched;
    logic checked;
  } acl_verdict_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_t;

  // Verdict predictor and checker
  class acl_scoreboard;
    bit [63:0] slot_addrs [RULE_SLOTS];
    bit [39:0] slot_ports [RULE_SLOTS];
    bit [1:0]  slot_flags [RULE_SLOTS];
    bit [6:0]  byte_cnt;
    bit [15:0] eth_type;
    bit [3:0]  hdr_words;
    bit [7:0]  ip_proto;
    bit [31:0] ip_src;
    bit [31:0] ip_dst;
    bit [15:0] l4_sport;
    bit [15:0] l4_dport;
    acl_verdict_t verdict_q[$];
    int errors;

    function void clear_frame();
      byte_cnt = '0;
      eth_type = '0;
      hdr_words = '0;
      ip_proto = '0;
      ip_src = '0;
      ip_dst = '0;
      l4_sport = '0;
      l4_dport = '0;
    endfunction

    // Lowest valid slot that matches the captured tuple, or -1
    function int find_rule(bit [15:0] sport);
      bit [63:0] addrs;
      bit [39:0] ports;
      addrs = {ip_src, ip_dst};
      ports = {ip_proto, sport, l4_dport};
      for (int i = 0; i < RULE_SLOTS; i++) begin
        if (slot_flags[i][FLAG_VALID] && slot_addrs[i] == addrs && slot_ports[i] == ports)
          return i;
      end
      return -1;
    endfunction

    // Feed one byte into every header field it lies in
    function void capture(int unsigned idx, bit [7:0] b);
      int unsigned ihl;
      int unsigned off;
      ihl = (idx == 14) ? b[7:4] : hdr_words;
      off = ETH_HDR_BYTES + 4 * ihl;
      if (idx == 12) eth_type[15:8] = b;
      if (idx == 13) eth_type[7:0] = b;
      if (idx == 14) hdr_words = b[7:4];
      if (idx == 23) ip_proto = b;
      if (idx >= 26 && idx <= 29) ip_src = {ip_src[23:0], b};
      if (idx >= 30 && idx <= 33) ip_dst = {ip_dst[23:0], b};
      if (idx == off) l4_sport[15:8] = b;
      if (idx == off + 1) l4_sport[7:0] = b;
      if (idx == off + 2) l4_dport[15:8] = b;
      if (idx == off + 3) l4_dport[7:0] = b;
    endfunction

    function void note_word(acl_word_t w);
      int unsigned frame_len;
      int unsigned need;
      int hit;
      acl_verdict_t v;
      // Rule writes only touch the table
      if (w.kind == KIND_RULE) begin
        if (w.rule_slot < RULE_SLOTS) begin
          slot_addrs[w.rule_slot] = {w.rule_src_addr, w.rule_dst_addr};
          slot_ports[w.rule_slot] = {w.rule_protocol, w.rule_src_port, w.rule_dst_port};
          slot_flags[w.rule_slot] = {w.rule_valid, w.rule_deny};
        end
        return;
      end
      capture(byte_cnt, w.pkt_byte);
      frame_len = byte_cnt + 1;
      if (byte_cnt < COUNT_MAX) byte_cnt++;
      if (!w.pkt_last) return;
      // Decide the frame on its last byte
      v = '0;
      need = ETH_HDR_BYTES + 4 * hdr_words + ((ip_proto == PROTO_TCP) ? TCP_NEED : UDP_NEED);
      if (eth_type == ETHERTYPE_IPV4 && frame_len >= MIN_IP_FRAME &&
          (ip_proto == PROTO_TCP || ip_proto == PROTO_UDP) && frame_len >= need) begin
        v.checked = 1'b1;
        hit = find_rule(WILDCARD_PORT);
        if (hit < 0) hit = find_rule(l4_sport);
        if (hit >= 0) begin
          v.matched = 1'b1;
          v.drop = slot_flags[hit][FLAG_DENY];
        end
      end
      verdict_q.push_back(v);
      clear_frame();
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_verdict(acl_verdict_t got);
      acl_verdict_t want;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict with none pending: drop=%0b matched=%0b checked=%0b",
                                  got.drop, got.matched, got.checked));
        return;
      end
      want = verdict_q.pop_front();
      if (got.drop !== want.drop)
        report_mismatch($sformatf("drop got %b want %b", got.drop, want.drop));
      if (got.matched !== want.matched)
        report_mismatch($sformatf("matched got %b want %b", got.matched, want.matched));
      if (got.checked !== want.checked)
        report_mismatch($sformatf("checked got %b want %b", got.checked, want.checked));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = KIND_BYTE;
  logic [7:0]  in_pkt_byte = '0;
  logic        in_pkt_last = 1'b0;
  logic [5:0]  in_rule_slot = '0;
  logic [31:0] in_rule_src_addr = '0;
  logic [31:0] in_rule_dst_addr = '0;
  logic [7:0]  in_rule_protocol = '0;
  logic [15:0] in_rule_src_port = '0;
  logic [15:0] in_rule_dst_port = '0;
  logic        in_rule_deny = 1'b0;
  logic        in_rule_valid = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_drop;
  logic        out_matched;
  logic        out_checked;

  acl_scoreboard sb = new();
  logic [7:0]  frame_buf[$];
  int          words_sent = 0;
  int          frames_sent = 0;
  bit          tx_idle_on = 1'b1;
  bit          hold_go = 1'b0;
  logic        rx_long_hold = 1'b0;
  logic        rx_idle_on = 1'b1;
  int          rx_gap = 0;
  int unsigned cycle_count = 0;

  ipv4_five_tuple_acl_filter_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_pkt_byte      (in_pkt_byte),
    .in_pkt_last      (in_pkt_last),
    .in_rule_slot     (in_rule_slot),
    .in_rule_src_addr (in_rule_src_addr),
    .in_rule_dst_addr (in_rule_dst_addr),
    .in_rule_protocol (in_rule_protocol),
    .in_rule_src_port (in_rule_src_port),
    .in_rule_dst_port (in_rule_dst_port),
    .in_rule_deny     (in_rule_deny),
    .in_rule_valid    (in_rule_valid),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_drop         (out_drop),
    .out_matched      (out_matched),
    .out_checked      (out_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Check verdicts and throttle out_ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_verdict(acl_verdict_t'({out_drop, out_matched, out_checked}));
    if (cycle_count % 300 == 0) rx_idle_on <= ($urandom_range(0, 2) != 0);
    if (rx_long_hold) begin
      out_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) rx_gap <= idle_len();
    end
  end

  // Hold the result channel off for a long stretch once asked
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_long_hold <= 1'b0;
  end

  function automatic acl_word_t random_word();
    acl_word_t w;
    w.kind = KIND_BYTE;
    w.pkt_byte = 8'($urandom);
    w.pkt_last = 1'($urandom);
    w.rule_slot = 6'($urandom);
    w.rule_src_addr = $urandom;
    w.rule_dst_addr = $urandom;
    w.rule_protocol = 8'($urandom);
    w.rule_src_port = 16'($urandom);
    w.rule_dst_port = 16'($urandom);
    w.rule_deny = 1'($urandom);
    w.rule_valid = 1'($urandom);
    return w;
  endfunction

  function automatic acl_word_t make_rule(logic [5:0] slot, flow_t f, logic deny, logic valid);
    acl_word_t w;
    w = random_word();
    w.kind = KIND_RULE;
    w.rule_slot = slot;
    w.rule_src_addr = f.src;
    w.rule_dst_addr = f.dst;
    w.rule_protocol = f.proto;
    w.rule_src_port = f.sport;
    w.rule_dst_port = f.dport;
    w.rule_deny = deny;
    w.rule_valid = valid;
    return w;
  endfunction

  function automatic logic [31:0] rand_addr();
    if ($urandom_range(0, 9) < 3) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'hC0A8_0A01;
      1: return 32'h0A00_0002;
      2: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_port();
    if ($urandom_range(0, 9) < 4) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'd80;
      1: return 16'd443;
      2: return 16'd53;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Tuple for a frame: often one already in the table, so lookups hit
  task automatic pick_flow(output flow_t f);
    int s;
    if ($urandom_range(0, 99) < 55) begin
      s = $urandom_range(0, RULE_SLOTS - 1);
      {f.src, f.dst} = sb.slot_addrs[s];
      {f.proto, f.sport, f.dport} = sb.slot_ports[s];
      if (f.sport == WILDCARD_PORT) f.sport = rand_port();
    end else begin
      f.src = rand_addr();
      f.dst = rand_addr();
      f.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
      f.sport = rand_port();
      f.dport = rand_port();
    end
  endtask

  function automatic acl_word_t rand_rule();
    flow_t f;
    f.src = rand_addr();
    f.dst = rand_addr();
    if ($urandom_range(0, 9) == 0) f.proto = 8'($urandom);
    else f.proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    f.sport = ($urandom_range(0, 9) < 4) ? WILDCARD_PORT : rand_port();
    f.dport = rand_port();
    return make_rule(6'($urandom), f, 1'($urandom), $urandom_range(0, 99) < 85);
  endfunction

  // Offer one word and hold it until accepted, then maybe idle
  task automatic send_word(input acl_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_kind <= w.kind;
    in_pkt_byte <= w.pkt_byte;
    in_pkt_last <= w.pkt_last;
    in_rule_slot <= w.rule_slot;
    in_rule_src_addr <= w.rule_src_addr;
    in_rule_dst_addr <= w.rule_dst_addr;
    in_rule_protocol <= w.rule_protocol;
    in_rule_src_port <= w.rule_src_port;
    in_rule_dst_port <= w.rule_dst_port;
    in_rule_deny <= w.rule_deny;
    in_rule_valid <= w.rule_valid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
    gap = (tx_idle_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void put_byte(int idx, logic [7:0] v);
    if (idx < frame_buf.size()) frame_buf[idx] = v;
  endfunction

  // Build a frame around the given header fields and stream it out;
  // a rule write may be slipped in before byte rule_at
  task automatic send_frame(input logic [15:0] ether, input int ihl, input flow_t f,
                            input int len, input int rule_at, input acl_word_t rule_w);
    int unsigned off;
    logic [31:0] ports;
    acl_word_t w;
    frame_buf = {};
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    ports = {f.sport, f.dport};
    off = ETH_HDR_BYTES + 4 * ihl;
    // Ports first, so header bytes win where a small IHL overlaps them
    for (int k = 0; k < 4; k++) put_byte(off + k, ports[31 - 8 * k -: 8]);
    put_byte(12, ether[15:8]);
    put_byte(13, ether[7:0]);
    put_byte(14, {4'(ihl), 4'($urandom)});
    put_byte(23, f.proto);
    for (int k = 0; k < 4; k++) begin
      put_byte(26 + k, f.src[31 - 8 * k -: 8]);
      put_byte(30 + k, f.dst[31 - 8 * k -: 8]);
    end
    for (int i = 0; i < len; i++) begin
      if (i == rule_at) send_word(rule_w);
      w = random_word();
      w.kind = KIND_BYTE;
      w.pkt_byte = frame_buf[i];
      w.pkt_last = (i == len - 1);
      send_word(w);
    end
    frames_sent++;
  endtask

  // Stop offering and wait for every pending verdict
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    flow_t fa, fa_wild, fb, fb_miss, fc, fd, fz, fx, fu;
    fa = '{src: 32'hC0A8_0A01, dst: 32'h0A00_0002, proto: PROTO_TCP,
           sport: 16'hC350, dport: 16'd80};
    fa_wild = fa;
    fa_wild.sport = WILDCARD_PORT;
    fb = '{src: 32'h0A01_0203, dst: 32'h0808_0808, proto: PROTO_UDP,
           sport: 16'h1234, dport: 16'd53};
    fb_miss = fb;
    fb_miss.sport = 16'h1235;
    fc = '{src: '1, dst: '1, proto: PROTO_TCP, sport: '1, dport: '1};
    fd = '{src: 32'hAC10_0001, dst: 32'hAC10_0002, proto: PROTO_UDP,
           sport: 16'd5000, dport: 16'd6000};
    fz = '{src: '0, dst: '0, proto: PROTO_TCP, sport: WILDCARD_PORT, dport: '0};
    fx = fa;
    fx.proto = 8'd1;
    fu = fa;
    fu.proto = PROTO_UDP;
    // Install rules, including a duplicate pair and both slot extremes
    send_word(make_rule(6'd0, fa_wild, 1'b1, 1'b1));
    send_word(make_rule(6'd5, fb, 1'b0, 1'b1));
    send_word(make_rule(6'd63, fc, 1'b1, 1'b1));
    send_word(make_rule(6'd10, fd, 1'b0, 1'b1));
    send_word(make_rule(6'd11, fd, 1'b1, 1'b1));
    send_word(make_rule(6'd32, fz, 1'b1, 1'b1));
    // Hits through the wildcard and the real source port, and one miss
    send_frame(ETHERTYPE_IPV4, 5, fa, 54, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fb, 42, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fb_miss, 60, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fc, 60, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fd, 50, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fz, 54, -1, '0);
    // Frames that must go unchecked
    send_frame(16'h86DD, 5, fa, 54, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fx, 54, -1, '0);
    send_frame(ETHERTYPE_IPV4, 0, fu, 33, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fa, 42, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fa, 1, -1, '0);
    send_frame(16'h0000, 0, fz, 60, -1, '0);
    // Header length extremes and a frame past counter saturation
    send_frame(ETHERTYPE_IPV4, 0, fa, 34, -1, '0);
    send_frame(ETHERTYPE_IPV4, 15, fa, 94, -1, '0);
    send_frame(ETHERTYPE_IPV4, 5, fa, 150, -1, '0);
    // Remove the wildcard rule while a frame is in flight
    send_frame(ETHERTYPE_IPV4, 5, fa, 54, 20, make_rule(6'd0, fa_wild, 1'b0, 1'b0));
  endtask

  // Fill the block while the result channel is held off
  task automatic run_backpressure();
    flow_t f;
    tx_idle_on = 1'b0;
    hold_go = 1'b1;
    repeat (4) begin
      pick_flow(f);
      f.proto = PROTO_TCP;
      send_frame(ETHERTYPE_IPV4, 5, f, 54, -1, '0);
    end
    tx_idle_on = 1'b1;
  endtask

  // Random traffic until the whole run has sent its word budget
  task automatic run_random();
    flow_t f;
    int r;
    int ihl;
    int need;
    int len;
    int rule_at;
    logic [15:0] ether;
    while (words_sent < TOTAL_WORDS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_word(rand_rule());
      end else begin
        pick_flow(f);
        if (r < 25) begin
          // Noise: arbitrary header, arbitrary length
          if ($urandom_range(0, 1)) f.proto = 8'($urandom);
          ether = $urandom_range(0, 2) ? 16'($urandom) : ETHERTYPE_IPV4;
          ihl = $urandom_range(0, 15);
          len = $urandom_range(1, 70);
        end else begin
          ether = ($urandom_range(0, 99) < 93) ? ETHERTYPE_IPV4 : 16'($urandom);
          ihl = $urandom_range(0, 3) ? 5 : $urandom_range(0, 15);
          need = ETH_HDR_BYTES + 4 * ihl + ((f.proto == PROTO_TCP) ? TCP_NEED : UDP_NEED);
          if (need < MIN_IP_FRAME) need = MIN_IP_FRAME;
          r = $urandom_range(0, 99);
          if (r < 80) len = need + $urandom_range(0, 12);
          else if (r < 90) len = need - $urandom_range(1, 4);
          else len = $urandom_range(128, 150);
        end
        rule_at = ($urandom_range(0, 99) < 6) ? $urandom_range(0, len - 1) : -1;
        send_frame(ether, ihl, f, len, rule_at, rand_rule());
        if (frames_sent % 16 == 0) wait_results();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_results();
    run_backpressure();
    wait_results();
    run_random();
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
